[hdl/h2dfs_pkg.sv]
// Shared types and constants for the streaming 2D Haar forward transform.
`timescale 1ns / 1ps
`default_nettype none

package h2dfs_pkg;

  localparam int PIXEL_W      = 16;
  localparam int COEFF_W      = 18;
  localparam int CFG_W        = 13;
  localparam int CFG_INDEX_W  = 8;
  localparam int ROW_W        = 12;
  localparam int HEIGHT_W     = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int FIFO_DEPTH   = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(512);
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(512);

  typedef logic signed [PIXEL_W-1:0] pixel_t;
  typedef logic signed [COEFF_W-1:0] coeff_t;

  // one complete 2x2 block: a upper left, b upper right, c lower left, d lower right
  typedef struct packed {
    pixel_t a;
    pixel_t b;
    pixel_t c;
    pixel_t d;
    logic   last;
  } block_t;

endpackage

`default_nettype wire

[hdl/h2dfs_front.sv]
// Front end: raster position tracking, line buffer, and 2x2 block assembly.
`timescale 1ns / 1ps
`default_nettype none

module h2dfs_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  input  wire  [h2dfs_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire  [h2dfs_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire                                   pix_valid_i,
  output logic                                  pix_ready_o,
  input  wire  [h2dfs_pkg::PIXEL_W-1:0]         pix_data_i,
  output logic                                  blk_valid_o,
  input  wire                                   blk_ready_i,
  output h2dfs_pkg::block_t                     blk_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = h2dfs_pkg::PIXEL_W;

  logic [h2dfs_pkg::CFG_W-1:0] width_q, width_d;
  logic [h2dfs_pkg::CFG_W-1:0] height_q, height_d;
  logic [CW-1:0] col_q, col_d;
  logic [h2dfs_pkg::ROW_W-1:0] row_q, row_d;
  h2dfs_pkg::pixel_t hold_q, hold_d;

  logic [WW-1:0] w_eff;
  logic [h2dfs_pkg::HEIGHT_W-1:0] h_eff;
  logic [WW-1:0] col_inc;
  logic [h2dfs_pkg::HEIGHT_W-1:0] row_inc;
  logic accept, cfg_hit, is_block, blk_last;
  logic mem_we, mem_re;
  logic [AW-1:0] pair_addr;

  logic [2*PW-1:0] mem [DEPTH];
  logic [2*PW-1:0] rd_q;

  logic s1_valid_q, s1_valid_d;
  h2dfs_pkg::pixel_t s1_c_q, s1_d_q;
  logic s1_last_q;
  logic push;

  // effective geometry: zero acts as one, oversize clamps
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = h2dfs_pkg::HEIGHT_W'(1);
    end else if (32'(height_q) > h2dfs_pkg::HEIGHT_LIMIT) begin
      h_eff = h2dfs_pkg::HEIGHT_W'(h2dfs_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = height_q;
    end
  end

  assign push        = s1_valid_q && blk_ready_i;
  assign pix_ready_o = !s1_valid_q || blk_ready_i;
  assign accept      = pix_valid_i && pix_ready_o;
  assign is_block    = row_q[0] && col_q[0];
  assign col_inc     = WW'(col_q) + WW'(1);
  assign row_inc     = h2dfs_pkg::HEIGHT_W'(row_q) + h2dfs_pkg::HEIGHT_W'(1);
  assign pair_addr   = AW'(col_q >> 1);
  assign mem_we      = accept && !row_q[0] && col_q[0];
  assign mem_re      = accept && is_block;

  assign blk_last = (h2dfs_pkg::HEIGHT_W'(row_q) ==
                     ((h_eff & ~h2dfs_pkg::HEIGHT_W'(1)) - h2dfs_pkg::HEIGHT_W'(1))) &&
                    (WW'(col_q) == ((w_eff & ~WW'(1)) - WW'(1)));

  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == h2dfs_pkg::REG_IMAGE_WIDTH ||
                    cfg_index_i == h2dfs_pkg::REG_IMAGE_HEIGHT);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    hold_d   = hold_q;
    if (cfg_hit) begin
      if (cfg_index_i == h2dfs_pkg::REG_IMAGE_WIDTH) begin
        width_d = cfg_data_i;
      end else begin
        height_d = cfg_data_i;
      end
      col_d  = '0;
      row_d  = '0;
      hold_d = '0;
    end else if (accept) begin
      // even column pixel is held: upper-left partner or lower-left c
      if (!col_q[0]) begin
        hold_d = h2dfs_pkg::pixel_t'(pix_data_i);
      end
      if (col_inc >= w_eff) begin
        col_d = '0;
        if (row_inc >= h_eff) begin
          row_d = '0;
        end else begin
          row_d = h2dfs_pkg::ROW_W'(row_inc);
        end
      end else begin
        col_d = CW'(col_inc);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (mem_re) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= h2dfs_pkg::IMAGE_WIDTH_RESET;
      height_q   <= h2dfs_pkg::IMAGE_HEIGHT_RESET;
      col_q      <= '0;
      row_q      <= '0;
      hold_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      hold_q     <= hold_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // line buffer holds pixel pairs: upper half even column, lower half odd column
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[pair_addr] <= {hold_q, pix_data_i};
    end
    if (mem_re) begin
      rd_q <= mem[pair_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_c_q    <= hold_q;
      s1_d_q    <= h2dfs_pkg::pixel_t'(pix_data_i);
      s1_last_q <= blk_last;
    end
  end

  assign blk_valid_o = s1_valid_q;
  assign blk_o.a     = h2dfs_pkg::pixel_t'(rd_q[2*PW-1:PW]);
  assign blk_o.b     = h2dfs_pkg::pixel_t'(rd_q[PW-1:0]);
  assign blk_o.c     = s1_c_q;
  assign blk_o.d     = s1_d_q;
  assign blk_o.last  = s1_last_q;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("line buffer written and read by the same word");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < w_eff)
    else $error("column position beyond effective width");

  a_block_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && s1_valid_q) |-> push)
    else $error("pending block overwritten before hand-off");

endmodule

`default_nettype wire

[hdl/h2dfs_fifo.sv]
// Short block queue between front end and coefficient stage.
`timescale 1ns / 1ps
`default_nettype none

module h2dfs_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_valid_i,
  output logic               push_ready_o,
  input  h2dfs_pkg::block_t  push_data_i,
  output logic               pop_valid_o,
  input  wire                pop_ready_i,
  output h2dfs_pkg::block_t  pop_data_o
);

  localparam int DEPTH = h2dfs_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  h2dfs_pkg::block_t store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill exceeds depth");

endmodule

`default_nettype wire

[hdl/h2dfs_back.sv]
// Back end: butterfly sums of one 2x2 block into a registered output word.
`timescale 1ns / 1ps
`default_nettype none

module h2dfs_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                blk_valid_i,
  output logic               blk_ready_o,
  input  h2dfs_pkg::block_t  blk_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output h2dfs_pkg::coeff_t  ll_o,
  output h2dfs_pkg::coeff_t  lh_o,
  output h2dfs_pkg::coeff_t  hl_o,
  output h2dfs_pkg::coeff_t  hh_o,
  output logic               last_o
);

  localparam int CWD = h2dfs_pkg::COEFF_W;

  logic out_valid_q, out_valid_d;
  h2dfs_pkg::coeff_t ll_q, lh_q, hl_q, hh_q;
  h2dfs_pkg::coeff_t a, b, c, d;
  h2dfs_pkg::coeff_t s_ab, d_ab, s_cd, d_cd;
  logic last_q;
  logic load;

  assign blk_ready_o = !out_valid_q || out_ready_i;
  assign load        = blk_valid_i && blk_ready_o;

  assign a = CWD'(blk_i.a);
  assign b = CWD'(blk_i.b);
  assign c = CWD'(blk_i.c);
  assign d = CWD'(blk_i.d);

  // top/bottom pair sums and differences first, then combine
  assign s_ab = a + b;
  assign d_ab = a - b;
  assign s_cd = c + d;
  assign d_cd = c - d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ll_q   <= s_ab + s_cd;
      lh_q   <= d_ab + d_cd;
      hl_q   <= s_ab - s_cd;
      hh_q   <= d_ab - d_cd;
      last_q <= blk_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ll_o        = ll_q;
  assign lh_o        = lh_q;
  assign hl_o        = hl_q;
  assign hh_o        = hh_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[hdl/haar_2d_forward_stream.sv]
// Top level of the streaming one-level 2D Haar forward transform.
// A result word passes the front-end block register, the block queue and the output register to m_axis.
// Throughput: one pixel per cycle sustained while m_axis is not stalled; at most one coefficient word per four pixels.
// The line-buffer read port (one pair read per block) and the 2x2 butterfly set the rate.
// Reset: geometry returns to 512 x 512, position to row 0 column 0; queue and output empty.
// The line buffer is not cleared: every entry read is written on the even row before.
`timescale 1ns / 1ps
`default_nettype none

module haar_2d_forward_stream #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration write channel; index 0 image_width, 1 image_height
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [h2dfs_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire  [h2dfs_pkg::CFG_W-1:0]         cfg_data_i,
  // pixel stream in
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [15:0]                         s_axis_tdata,  // [15:0] pixel
  // coefficient stream out
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [71:0]                         m_axis_tdata,  // [17:0] ll_coeff, [35:18] lh_coeff,
                                                             // [53:36] hl_coeff, [71:54] hh_coeff
  output logic                                m_axis_tlast   // frame_last
);

  // front -> queue
  logic              f_valid, f_ready;
  h2dfs_pkg::block_t f_blk;
  // queue -> back
  logic              q_valid, q_ready;
  h2dfs_pkg::block_t q_blk;

  h2dfs_pkg::coeff_t ll, lh, hl, hh;

  // configuration is taken every cycle; the user must write it only while the block is idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  // front end: tracks raster position, writes even rows into the pair buffer,
  // and emits one block word on every odd-row odd-column pixel
  h2dfs_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_data_i  (s_axis_tdata),
    .blk_valid_o (f_valid),
    .blk_ready_i (f_ready),
    .blk_o       (f_blk)
  );

  // short queue decouples the pixel side from output back-pressure
  h2dfs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_blk),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_blk)
  );

  // back end: four-sample butterflies into the output register
  h2dfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (q_valid),
    .blk_ready_o (q_ready),
    .blk_i       (q_blk),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ll_o        (ll),
    .lh_o        (lh),
    .hl_o        (hl),
    .hh_o        (hh),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {hh, hl, lh, ll};

endmodule

`default_nettype wire

[tb/haar_2d_forward_stream_tb.sv]
// Self-checking testbench for the streaming one-level 2D Haar forward transform.
`timescale 1ns / 1ps

module haar_2d_forward_stream_tb;
  import h2dfs_pkg::*;

  localparam int LINE_MAX      = 4096;  // maximum image width of the instance
  localparam int RANDOM_PIXELS = 360;   // random pixels that can form blocks
  localparam int SETTLE_CYCLES = 6;     // margin past the last output word
  localparam int REPORT_LIMIT  = 10;

  // one coefficient word as the block should emit it
  typedef struct packed {
    coeff_t ll;
    coeff_t lh;
    coeff_t hl;
    coeff_t hh;
    logic   last;
  } coeff_set_t;

  // Tracks geometry, raster position and the line buffer, predicts one word
  // per completed 2x2 block and checks returned words in order.
  class coeff_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pixel_t           line_buf [LINE_MAX];
    int unsigned      col_pos;
    int unsigned      row_pos;
    pixel_t           held_left;
    coeff_set_t       pending_coeffs [$];
    int unsigned      mismatch_count;

    function new();
      width_reg      = IMAGE_WIDTH_RESET;
      height_reg     = IMAGE_HEIGHT_RESET;
      col_pos        = 0;
      row_pos        = 0;
      held_left      = '0;
      mismatch_count = 0;
    endfunction

    // any geometry write restarts the frame; line buffer keeps its contents
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH: width_reg = val;
        REG_IMAGE_HEIGHT: height_reg = val;
        default: return;
      endcase
      col_pos   = 0;
      row_pos   = 0;
      held_left = '0;
    endfunction

    function void note_pixel(pixel_t px);
      int unsigned w, h, c, r;
      int a, b, lo_l, lo_r;
      coeff_set_t e;
      w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      if (!r[0]) begin
        line_buf[c] = px;
      end else if (!c[0]) begin
        held_left = px;
      end else begin
        a    = line_buf[c-1];
        b    = line_buf[c];
        lo_l = held_left;
        lo_r = px;
        e.ll   = coeff_t'(a + b + lo_l + lo_r);
        e.lh   = coeff_t'(a - b + lo_l - lo_r);
        e.hl   = coeff_t'(a + b - lo_l - lo_r);
        e.hh   = coeff_t'(a - b - lo_l + lo_r);
        e.last = (r == (h & ~32'd1) - 1) && (c == (w & ~32'd1) - 1);
        pending_coeffs.push_back(e);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    function void flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_word(logic [4*COEFF_W-1:0] data, logic last_flag);
      coeff_set_t got, want;
      got.ll   = data[COEFF_W-1:0];
      got.lh   = data[2*COEFF_W-1:COEFF_W];
      got.hl   = data[3*COEFF_W-1:2*COEFF_W];
      got.hh   = data[4*COEFF_W-1:3*COEFF_W];
      got.last = last_flag;
      if (pending_coeffs.size() == 0) begin
        flag_mismatch($sformatf("unexpected word ll=%0d lh=%0d hl=%0d hh=%0d last=%0b",
                                got.ll, got.lh, got.hl, got.hh, got.last));
        return;
      end
      want = pending_coeffs.pop_front();
      if (got.ll !== want.ll || got.lh !== want.lh || got.hl !== want.hl ||
          got.hh !== want.hh || got.last !== want.last) begin
        flag_mismatch($sformatf(
          "expected ll=%0d lh=%0d hl=%0d hh=%0d last=%0b, got ll=%0d lh=%0d hl=%0d hh=%0d last=%0b",
          want.ll, want.lh, want.hl, want.hh, want.last,
          got.ll, got.lh, got.hl, got.hh, got.last));
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [71:0]            m_axis_tdata;
  logic                   m_axis_tlast;

  coeff_scoreboard sb = new();

  // sender pacing: words left in the current burst
  int burst_left = 0;

  // receiver stall pattern state
  bit rx_ready = 1'b0;
  int rx_run   = 0;

  haar_2d_forward_stream #(
    .MAX_WIDTH (LINE_MAX)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: alternates ready and stall runs of random length. Now and then
  // a long stall lets the output queue fill and pushes back on the pixel
  // side; now and then a long ready run gives a stretch with no stalls.
  always @(negedge clk_i) begin
    if (rx_run == 0) begin
      rx_ready = !rx_ready;
      if (rx_ready) rx_run = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
      else          rx_run = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 6);
    end
    m_axis_tready = rx_ready;
    rx_run--;
  end

  // every accepted coefficient word goes straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
  end

  function automatic pixel_t random_pixel();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // After each accepted word: either stay in the burst (valid stays high)
  // or start a new burst, in most cases after dropping valid for a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if ($urandom_range(0, 7) == 0) begin
      gap        = 0;
      burst_left = $urandom_range(100, 400);
    end else begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic push_pixel(pixel_t px);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(px);
    pace_sender();
  endtask

  task automatic send_random(int count);
    repeat (count) push_pixel(random_pixel());
  endtask

  // raster order of one 2x2 block when the width is two
  task automatic send_block(pixel_t a, pixel_t b, pixel_t c, pixel_t d);
    push_pixel(a);
    push_pixel(b);
    push_pixel(c);
    push_pixel(d);
  endtask

  // hold the pixel side until every predicted word is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending_coeffs.size() != 0) @(posedge clk_i);
  endtask

  // Geometry writes only with the block idle; trailing pixels that form no
  // block may still be in flight, so let the design settle past the last word.
  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    int random_count;
    int w, h, n;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry: the start of a 512-wide row forms no block
    send_random(8);
    // narrow rows under the reset height: words come, none flagged last
    write_cfg(REG_IMAGE_WIDTH, 13'd4);
    send_random(16);

    // 2 x 2 frames: every block is the last of its frame; extreme sums
    write_cfg(REG_IMAGE_WIDTH, 13'd2);
    write_cfg(REG_IMAGE_HEIGHT, 13'd2);
    send_block(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);  // LL max
    send_block(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);  // LL min
    send_block(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);  // LH max
    send_block(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);  // HL min
    send_block(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);  // HH max

    // zero width acts as one column: pixels consumed, no blocks
    write_cfg(REG_IMAGE_WIDTH, 13'd0);
    send_random(3);
    write_cfg(REG_IMAGE_WIDTH, 13'd1);
    send_random(2);
    // zero or one row: never an odd row, no blocks
    write_cfg(REG_IMAGE_WIDTH, 13'd4);
    write_cfg(REG_IMAGE_HEIGHT, 13'd0);
    send_random(4);
    write_cfg(REG_IMAGE_HEIGHT, 13'd1);
    send_random(4);
    // odd geometry: trailing column and row dropped, one block flagged last
    write_cfg(REG_IMAGE_WIDTH, 13'd3);
    write_cfg(REG_IMAGE_HEIGHT, 13'd3);
    send_random(9);

    // oversize values clamp to the largest geometry: start of row zero, no block
    write_cfg(REG_IMAGE_WIDTH, 13'd8191);
    write_cfg(REG_IMAGE_HEIGHT, 13'd8191);
    send_random(8);
    // narrow rows under an oversize height: words come, none flagged last
    write_cfg(REG_IMAGE_WIDTH, 13'd2);
    send_random(12);

    // Random part: mostly small geometries that complete blocks and frames,
    // sometimes degenerate ones; phases may stop mid-frame, so the next write
    // also exercises the restart. Pixels of degenerate phases do not count.
    random_count = 0;
    while (random_count < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      write_cfg(REG_IMAGE_WIDTH, CFG_W'(w));
      write_cfg(REG_IMAGE_HEIGHT, CFG_W'(h));
      n = $urandom_range(1, 3 * w * h + 4);
      if (n > 150) n = 150;
      repeat (n) begin
        push_pixel(random_pixel());
        // occasional hold-off until the output side has caught up
        if ($urandom_range(0, 39) == 0) drain_results();
      end
      if (w >= 2 && h >= 2) random_count += n;
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending_coeffs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
